// ===== hw/rtl/lzw_pkg.sv =====
// lzw_pkg: widths, constants and sequencer states for the lzw byte compressor
// used by hw/rtl/lzw_byte_compressor.sv and its checker
package lzw_pkg;
  localparam int CodeBits = 12;
  localparam int CodeCount = 1 << CodeBits;
  localparam int KeyBits = CodeBits + 8;
  localparam logic [CodeBits:0] FirstLearned = (CodeBits + 1)'(257);

  typedef logic [CodeBits-1:0] code_t;
  typedef logic [CodeBits:0] count_t;
  typedef logic [KeyBits-1:0] key_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;
endpackage

// ===== hw/rtl/lzw_byte_compressor.sv =====
// lzw_byte_compressor: lzw compressor, one byte in, up to two codes out per item
// depends on lzw_pkg; holds the learned-pair memory and the search sequencer
//
//   channel | signals                         | direction
//   in      | valid, stall, data_byte, last_byte| item in
//   out     | out_valid, out_stall, out_code,  | code out
//           | last_code                       |
//
// a byte with a current code probes learned codes 257 upward, one read and one compare each
// a hit ends the search at that code; a miss probes every learned code and then emits
// the first byte of a stream only sets the current code; the last byte adds a flush
// the search uses the single memory read port and the one key comparator; codes leave through the output register
// reset returns to an empty table at once (fill count, no clearing pass)
// the block stalls its input while a code waits on out_stall
module lzw_byte_compressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output lzw_pkg::code_t out_code,
  output logic       last_code
);
  lzw_pkg::state_t state;
  lzw_pkg::key_t   mem [lzw_pkg::CodeCount];
  lzw_pkg::key_t   rd_data;
  lzw_pkg::count_t next_free;
  lzw_pkg::count_t probe;
  lzw_pkg::code_t  cur;
  logic [7:0]      byte_q;
  logic            last_q;
  lzw_pkg::key_t   key;
  logic            done;

  assign key = {cur, byte_q};
  assign stall = (state != lzw_pkg::S_IDLE) || out_valid;
  // search is over when no learned code remains to probe
  assign done = (probe >= next_free);

  always_ff @(posedge clk) begin
    rd_data <= mem[probe[lzw_pkg::CodeBits-1:0]];
    if (state == lzw_pkg::S_EMIT && next_free[lzw_pkg::CodeBits] == 1'b0) begin
      mem[next_free[lzw_pkg::CodeBits-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzw_pkg::S_IDLE;
      next_free <= lzw_pkg::FirstLearned;
      cur <= '0;
      out_valid <= 1'b0;
      probe <= lzw_pkg::FirstLearned;
    end else begin
      // the flush state reloads the output register itself
      if (out_valid && !out_stall && state != lzw_pkg::S_FLUSH) out_valid <= 1'b0;
      unique case (state)
        lzw_pkg::S_IDLE: begin
          if (valid && !stall) begin
            byte_q <= data_byte;
            last_q <= last_byte;
            probe <= lzw_pkg::FirstLearned;
            if (cur == '0) begin
              cur <= lzw_pkg::code_t'({1'b0, data_byte} + 9'd1);
              if (last_byte) state <= lzw_pkg::S_FLUSH;
            end else begin
              state <= lzw_pkg::S_READ;
            end
          end
        end
        lzw_pkg::S_READ: begin
          if (done) state <= lzw_pkg::S_EMIT;
          else state <= lzw_pkg::S_CMP;
        end
        lzw_pkg::S_CMP: begin
          if (rd_data == key) begin
            cur <= probe[lzw_pkg::CodeBits-1:0];
            state <= last_q ? lzw_pkg::S_FLUSH : lzw_pkg::S_IDLE;
          end else begin
            probe <= probe + 1'b1;
            state <= lzw_pkg::S_READ;
          end
        end
        lzw_pkg::S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_code <= cur;
            last_code <= 1'b0;
            if (next_free[lzw_pkg::CodeBits] == 1'b0) next_free <= next_free + 1'b1;
            cur <= lzw_pkg::code_t'({1'b0, byte_q} + 9'd1);
            state <= last_q ? lzw_pkg::S_FLUSH : lzw_pkg::S_IDLE;
          end
        end
        lzw_pkg::S_FLUSH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_code <= cur;
            last_code <= 1'b1;
            cur <= '0;
            next_free <= lzw_pkg::FirstLearned;
            state <= lzw_pkg::S_IDLE;
          end
        end
        default: state <= lzw_pkg::S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/lzw_checker.sv =====
// lzw_checker: port-level assertions for the lzw byte compressor
// depends on lzw_pkg and the lzw_byte_compressor ports; bound at the end of this file
module lzw_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       stall,
  input logic       out_valid,
  input logic       out_stall,
  input lzw_pkg::code_t out_code,
  input logic       last_code
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_code))
    else $error("output item changed while stalled");
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_code != '0)
    else $error("code zero emitted");
  a_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stall)
    else $error("input taken while a code waits");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind lzw_byte_compressor lzw_checker u_lzw_checker (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_code(out_code), .last_code(last_code)
);

// ===== verif/lzw_byte_compressor_test.sv =====
// lzw_byte_compressor_test: self-checking testbench for the lzw byte compressor
// depends on lzw_pkg and hw/rtl/lzw_byte_compressor.sv; predicts codes with its own dictionary
module lzw_byte_compressor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  typedef struct packed {
    lzw_pkg::code_t code;
    logic           last;
  } code_item_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           valid = 1'b0;
  logic           stall;
  logic [7:0]     data_byte = '0;
  logic           last_byte = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  lzw_pkg::code_t out_code;
  logic           last_code;

  lzw_byte_compressor i_dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code(out_code), .last_code(last_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  lzw_pkg::code_t  learned_pairs [lzw_pkg::key_t];
  lzw_pkg::count_t free_code;
  lzw_pkg::code_t  cur_code;
  code_item_t      pending_codes[$];

  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  int  hold_cycles = 0;

  function automatic void clear_dictionary();
    learned_pairs.delete();
    free_code = lzw_pkg::FirstLearned;
    cur_code  = '0;
  endfunction

  function automatic void queue_code(lzw_pkg::code_t code, logic last);
    code_item_t item;
    item.code = code;
    item.last = last;
    pending_codes = {pending_codes, item};
  endfunction

  function automatic void predict_codes(logic [7:0] b, logic last);
    lzw_pkg::key_t key;
    if (cur_code == '0) begin
      cur_code = lzw_pkg::code_t'(b) + 1'b1;
    end else begin
      key = {cur_code, b};
      if (learned_pairs.exists(key)) begin
        cur_code = learned_pairs[key];
      end else begin
        queue_code(cur_code, 1'b0);
        if (free_code < lzw_pkg::CodeCount) begin
          learned_pairs[key] = free_code[lzw_pkg::CodeBits-1:0];
          free_code++;
        end
        cur_code = lzw_pkg::code_t'(b) + 1'b1;
      end
    end
    if (last) begin
      queue_code(cur_code, 1'b1);
      clear_dictionary();
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("lzw_byte_compressor_test: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    code_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code %0d last %0b", $time, out_code, last_code);
        errors++;
      end else begin
        exp_item = pending_codes.pop_front();
        if (out_code !== exp_item.code) begin
          $display("%0t: out_code expected %0d actual %0d", $time, exp_item.code, out_code);
          errors++;
        end
        if (last_code !== exp_item.last) begin
          $display("%0t: last_code expected %0b actual %0b", $time, exp_item.last, last_code);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 7) begin
      valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    valid     <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (stall);
    predict_codes(b, last);
  endtask

  task automatic send_stream(int len, int alphabet);
    int base;
    base = $urandom_range(255);
    for (int i = 0; i < len; i++) begin
      if (alphabet >= 256) send_byte(8'($urandom), i == len - 1);
      else send_byte(8'(base + $urandom_range(alphabet - 1)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // repeated byte exercises hits on learned strings
    for (int i = 0; i < 7; i++) send_byte(8'h41, i == 6);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'(8'h55 ^ (i[0] ? 8'hff : 8'h00)), i == 7);
  endtask

  task automatic test_random_streams();
    for (int n = 0; n < 300; ) begin
      int len;
      len = $urandom_range(1, 20);
      send_stream(len, ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 4));
      n += len;
    end
  endtask

  task automatic test_no_idle_long_stream();
    quiet = 1'b1;
    send_stream(100, 3);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 200;
    send_stream(20, 2);
    wait_drained();
    send_stream(10, 256);
  endtask

  initial begin
    clear_dictionary();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_streams();
    test_no_idle_long_stream();
    test_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("lzw_byte_compressor_test: done, clean");
    end else begin
      $display("lzw_byte_compressor_test: done, errors");
    end
    $finish;
  end
endmodule
